// ===== rtl/gtba_pkg.sv =====
`default_nettype none

package gtba_pkg;

    localparam int unsigned ADDR_W   = 20;
    localparam int unsigned PIXEL_W  = 32;
    localparam int unsigned STRIDE_W = 11;
    localparam int unsigned WIDTH_W  = 11;
    localparam int unsigned GADDR_W  = 11;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned SX_W     = 10;
    localparam int unsigned SY_W     = 9;
    localparam int unsigned INDEX_W  = 7;
    localparam int unsigned ROWCOL_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_STRIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR    = 2'd3;

    localparam logic [STRIDE_W-1:0] RST_BUFFER_STRIDE = 11'd512;
    localparam logic [WIDTH_W-1:0]  RST_SCREEN_WIDTH  = 11'd480;
    localparam logic [PIXEL_W-1:0]  RST_FORE_COLOR    = 32'h00FF_FFFF;
    localparam logic [PIXEL_W-1:0]  RST_BACK_COLOR    = 32'hFF00_0000;

    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic                command;
        logic [GADDR_W-1:0]  glyph_address;
        logic [7:0]          glyph_byte;
        logic [CODE_W-1:0]   char_code;
        logic [SX_W-1:0]     start_x;
        logic [SY_W-1:0]     start_y;
        logic [INDEX_W-1:0]  char_index;
        logic [ROWCOL_W-1:0] glyph_row;
        logic [ROWCOL_W-1:0] glyph_col;
        logic [PIXEL_W-1:0]  old_pixel;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [PIXEL_W-1:0] pixel_value;
        logic               write_enable;
    } t_out_item;

    typedef struct packed {
        logic [STRIDE_W-1:0] buffer_stride;
        logic [WIDTH_W-1:0]  screen_width;
        logic [PIXEL_W-1:0]  fore_color;
        logic [PIXEL_W-1:0]  back_color;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/gtba_glyph_store.sv =====
`default_nettype none

module gtba_glyph_store #(
    parameter int unsigned ENTRIES = 2048
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  wire logic [7:0]                 i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(ENTRIES)-1:0] i_raddr,
    output logic      [7:0]                 o_rdata
);

    logic [7:0] r_mem [ENTRIES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/gtba_pixel_calc.sv =====
`default_nettype none

module gtba_pixel_calc (
    input  wire gtba_pkg::t_in_item  i_item,
    input  wire logic [7:0]          i_glyph_bits,
    input  wire gtba_pkg::t_cfg      i_cfg,
    output gtba_pkg::t_out_item      o_result
);

    logic [2:0]  bit_sel;
    logic        fg_hit;
    logic [31:0] color;
    logic [7:0]  alpha;
    logic [7:0]  inv;
    logic [15:0] pm_r;
    logic [15:0] pm_g;
    logic [15:0] pm_b;
    logic [31:0] premul;
    logic [15:0] bl_r;
    logic [15:0] bl_g;
    logic [15:0] bl_b;
    logic [31:0] blend;
    logic [9:0]  line;
    logic [20:0] line_base;
    logic [19:0] address;
    logic        on_screen;
    logic        draw;
    logic        we;
    logic        render;

    always_comb begin
        render = (i_item.command == gtba_pkg::CMD_RENDER);

        // Glyph bits are stored with the leftmost pixel in the MSB.
        bit_sel = 3'd7 - i_item.glyph_col;
        fg_hit  = i_glyph_bits[bit_sel];
        color   = fg_hit ? i_cfg.fore_color : i_cfg.back_color;
        alpha   = color[31:24];
        inv     = gtba_pkg::ALPHA_OPAQUE - alpha;

        pm_r = color[23:16] * inv;
        pm_g = color[15:8] * inv;
        pm_b = color[7:0] * inv;
        if (alpha == gtba_pkg::ALPHA_CLEAR || alpha == gtba_pkg::ALPHA_OPAQUE) begin
            premul = color;
        end else begin
            premul = {alpha, pm_r[15:8], pm_g[15:8], pm_b[15:8]};
        end

        bl_r  = i_item.old_pixel[23:16] * alpha;
        bl_g  = i_item.old_pixel[15:8] * alpha;
        bl_b  = i_item.old_pixel[7:0] * alpha;
        blend = {8'h00, premul[23:0]} + {8'h00, bl_r[15:8], bl_g[15:8], bl_b[15:8]};

        line      = {1'b0, i_item.start_y} + {7'b0, i_item.glyph_row};
        line_base = line * i_cfg.buffer_stride;
        address   = line_base[19:0] + {10'b0, i_item.start_x}
                  + {10'b0, i_item.char_index, 3'b000} + {17'b0, i_item.glyph_col};

        on_screen = ({1'b0, i_item.char_index} < i_cfg.screen_width[10:3]);
        draw      = render && (i_cfg.buffer_stride != '0) && on_screen;
        we        = draw && (alpha != gtba_pkg::ALPHA_OPAQUE);

        o_result.write_enable  = we;
        o_result.pixel_address = render ? address : '0;
        if (!we) begin
            o_result.pixel_value = '0;
        end else if (alpha == gtba_pkg::ALPHA_CLEAR) begin
            o_result.pixel_value = premul;
        end else begin
            o_result.pixel_value = blend;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/glyph_text_blit_alpha_top.sv =====
// The glyph store read and the blend each take one stage; the blend result is registered.
// Throughput: one request per cycle while the output is not stalled.
// Every request, load or render, gives exactly one result.
// Reset clears the pipeline valid flags and loads the configuration reset values.
// The glyph store is not cleared; entries are undefined until loaded.
`default_nettype none

module glyph_text_blit_alpha_top #(
    parameter int unsigned GLYPH_ENTRIES = 2048
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire gtba_pkg::t_in_item                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output gtba_pkg::t_out_item                      o_out_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [gtba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [gtba_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned GAW = $clog2(GLYPH_ENTRIES);
    localparam logic [gtba_pkg::GADDR_W:0] ENTRIES_LIM = (gtba_pkg::GADDR_W + 1)'(GLYPH_ENTRIES);

    gtba_pkg::t_cfg      r_cfg;
    gtba_pkg::t_in_item  r_s1;
    logic                r_s1_valid;
    logic                r_s1_gok;
    gtba_pkg::t_out_item r_out;
    logic                r_out_valid;
    gtba_pkg::t_out_item calc_result;

    logic                          advance;
    logic                          in_accept;
    logic [gtba_pkg::GADDR_W-1:0]  gidx;
    logic                          gidx_ok;
    logic                          load_ok;
    logic                          mem_we;
    logic                          mem_re;
    logic [7:0]                    mem_rdata;
    logic [7:0]                    glyph_bits;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign gidx    = {i_in_data.char_code, i_in_data.glyph_row};
    assign gidx_ok = ({1'b0, gidx} < ENTRIES_LIM);
    assign load_ok = ({1'b0, i_in_data.glyph_address} < ENTRIES_LIM);
    assign mem_we  = in_accept && (i_in_data.command == gtba_pkg::CMD_LOAD) && load_ok;
    assign mem_re  = in_accept && (i_in_data.command == gtba_pkg::CMD_RENDER);

    gtba_glyph_store #(
        .ENTRIES (GLYPH_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_in_data.glyph_address[GAW-1:0]),
        .i_wdata (i_in_data.glyph_byte),
        .i_re    (mem_re),
        .i_raddr (gidx[GAW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Rows past the end of the store read as blank.
    assign glyph_bits = r_s1_gok ? mem_rdata : 8'h00;

    gtba_pixel_calc u_calc (
        .i_item       (r_s1),
        .i_glyph_bits (glyph_bits),
        .i_cfg        (r_cfg),
        .o_result     (calc_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_cfg.buffer_stride <= gtba_pkg::RST_BUFFER_STRIDE;
            r_cfg.screen_width  <= gtba_pkg::RST_SCREEN_WIDTH;
            r_cfg.fore_color    <= gtba_pkg::RST_FORE_COLOR;
            r_cfg.back_color    <= gtba_pkg::RST_BACK_COLOR;
        end else begin
            if (!r_s1_valid || advance) begin
                r_s1_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gtba_pkg::REG_BUFFER_STRIDE: begin
                        r_cfg.buffer_stride <= i_cfg_data[gtba_pkg::STRIDE_W-1:0];
                    end
                    gtba_pkg::REG_SCREEN_WIDTH: begin
                        r_cfg.screen_width <= i_cfg_data[gtba_pkg::WIDTH_W-1:0];
                    end
                    gtba_pkg::REG_FORE_COLOR: begin
                        r_cfg.fore_color <= i_cfg_data[gtba_pkg::PIXEL_W-1:0];
                    end
                    gtba_pkg::REG_BACK_COLOR: begin
                        r_cfg.back_color <= i_cfg_data[gtba_pkg::PIXEL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1     <= i_in_data;
            r_s1_gok <= gidx_ok;
        end
        if (advance && r_s1_valid) begin
            r_out <= calc_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    ap_quiet_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.write_enable) |-> (o_out_data.pixel_value == '0))
        else $error("result without write enable carries a nonzero pixel value");

    ap_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("request accepted while both stages are full and stalled");

    ap_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted request did not reach the first stage");

    ap_load_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && advance && (r_s1.command == gtba_pkg::CMD_LOAD))
            |=> (o_out_valid && !o_out_data.write_enable))
        else $error("glyph load produced a pixel write");

    ap_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && advance) |=> o_out_valid)
        else $error("first stage item was dropped on its way to the output");

endmodule

`default_nettype wire
